// ===== design/srtt_pkg.sv =====
// ----------------------------------------------------------------------------
// srtt_pkg
// Shared types and constants for the sorted sample table: request codes,
// result status codes, field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package srtt_pkg;

    // default table size
    localparam int DEF_TABLE_DEPTH = 1024;

    // field widths
    localparam int KIND_W      = 2;
    localparam int SAMPLE_W    = 32;
    localparam int RANK_W      = 10;
    localparam int STATUS_W    = 2;
    localparam int TS_W        = 32;
    localparam int COUNT_OUT_W = 11;
    localparam int SECS_W      = 13;

    // window register reset value
    localparam logic [SECS_W-1:0] SECS_RESET = 13'd10;

    // scaling constants
    localparam logic [19:0]       US_PER_S   = 20'd1000000;
    localparam logic [SAMPLE_W:0] FULL_SCALE = 33'h0_FFFF_FFFF;

    // request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_READ   = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // controller to datapath commands
    typedef struct packed {
        logic    capture;    // latch a new request
        logic    clear;      // empty the table
        logic    rd_rank;    // read the entry at the requested rank
        logic    rd_ins;     // first read of the insert scan
        logic    ins_shift;  // move an entry up one place
        logic    ins_place;  // write the new sample, bump the count
        logic    scale_en;   // advance the scaling pipeline
        logic    ts_load;    // take the final scaled value
        logic    status_we;  // write the status code below
        t_status status;
        logic    out_load;   // move the result into the output register
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        t_kind kind;
        logic  full;
        logic  rank_bad;
        logic  shift_go;
    } t_dp_stat;

endpackage

// ===== design/srtt_dp.sv =====
// ----------------------------------------------------------------------------
// srtt_dp
// Datapath: request registers, the sorted sample memory with one write and
// one registered read port, the entry count, the scaling pipeline and the
// result output register.
// ----------------------------------------------------------------------------
module srtt_dp
    import srtt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    input  logic [KIND_W-1:0]      i_kind,
    input  logic [SAMPLE_W-1:0]    i_sample_value,
    input  logic [RANK_W-1:0]      i_rank,
    input  logic                   i_cfg_we,
    input  logic [SECS_W-1:0]      i_cfg_wdata,
    output logic [STATUS_W-1:0]    o_status,
    output logic [TS_W-1:0]        o_timestamp_us,
    output logic [COUNT_OUT_W-1:0] o_entry_count
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CW > RANK_W) ? CW : RANK_W;
    localparam int PROD_W = SAMPLE_W + SECS_W;     // sample times seconds
    localparam int LO_W   = 23;                    // low slice of the product
    localparam int HI_W   = PROD_W - LO_W;
    localparam int X_W    = PROD_W + 20;           // product times 10^6
    localparam int H_W    = X_W - SAMPLE_W;

    // request and state registers
    t_kind                r_kind;
    logic [SAMPLE_W-1:0]  r_sample;
    logic [RANK_W-1:0]    r_rank;
    logic [SECS_W-1:0]    r_secs;
    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_pos;
    t_status              r_status;
    logic [TS_W-1:0]      r_ts;

    // sample memory
    logic [SAMPLE_W-1:0]  r_mem [TABLE_DEPTH];
    logic [SAMPLE_W-1:0]  r_rd_data;

    // scaling pipeline
    logic [PROD_W-1:0]    r_prod;
    logic [LO_W+19:0]     r_lo;
    logic [HI_W+19:0]     r_hi;
    logic [X_W-1:0]       r_x;
    logic [H_W-1:0]       r_h;
    logic [H_W:0]         r_s;

    // output register
    logic [STATUS_W-1:0]    r_o_status;
    logic [TS_W-1:0]        r_o_ts;
    logic [COUNT_OUT_W-1:0] r_o_count;

    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [SAMPLE_W-1:0] wr_data;
    logic [1:0]          s_hi;
    logic [SAMPLE_W:0]   s_rem;
    logic                s_carry;
    logic [H_W+1:0]      quot;

    // status toward the controller
    always_comb begin
        o_stat.kind     = r_kind;
        o_stat.full     = (r_count == CW'(TABLE_DEPTH));
        o_stat.rank_bad = (CMP_W'(r_rank) >= CMP_W'(r_count));
        o_stat.shift_go = (r_pos != '0) && (r_rd_data > r_sample);
    end

    // memory port control
    always_comb begin
        rd_en = i_cmd.rd_rank
              | (i_cmd.rd_ins & (r_pos != '0))
              | (i_cmd.ins_shift & (r_pos > AW'(1)));
        if (i_cmd.rd_rank) begin
            rd_addr = AW'(r_rank);
        end else if (i_cmd.ins_shift) begin
            rd_addr = r_pos - AW'(2);
        end else begin
            rd_addr = r_pos - AW'(1);
        end
        wr_en   = i_cmd.ins_shift | i_cmd.ins_place;
        wr_data = i_cmd.ins_shift ? r_rd_data : r_sample;
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_pos] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // control state: count and window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_secs  <= SECS_RESET;
        end else begin
            if (i_cfg_we) begin
                r_secs <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.ins_place) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    // request capture and insert position
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= t_kind'(i_kind);
            r_sample <= i_sample_value;
            r_rank   <= i_rank;
            r_pos    <= AW'(r_count);
        end else if (i_cmd.ins_shift) begin
            r_pos <= r_pos - AW'(1);
        end
    end

    // result status and timestamp
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_status <= ST_OK;
            r_ts     <= '0;
        end else begin
            if (i_cmd.status_we) begin
                r_status <= i_cmd.status;
            end
            if (i_cmd.ts_load) begin
                r_ts <= (quot[H_W+1:TS_W] != '0) ? '1 : quot[TS_W-1:0];
            end
        end
    end

    // division by 2^32-1 using 2^32 = 1 modulo the divisor
    always_comb begin
        s_hi    = r_s[H_W:SAMPLE_W];
        s_rem   = {1'b0, r_s[SAMPLE_W-1:0]} + (SAMPLE_W + 1)'(s_hi);
        s_carry = (s_rem >= FULL_SCALE);
        quot    = (H_W + 2)'(r_h) + (H_W + 2)'(s_hi) + (H_W + 2)'(s_carry);
    end

    // scaling pipeline: multiply, times 10^6 in two slices, sum, fold
    always_ff @(posedge i_clk) begin
        if (i_cmd.scale_en) begin
            r_prod <= PROD_W'(r_rd_data) * PROD_W'(r_secs);
            r_lo   <= (LO_W + 20)'(r_prod[LO_W-1:0]) * (LO_W + 20)'(US_PER_S);
            r_hi   <= (HI_W + 20)'(r_prod[PROD_W-1:LO_W]) * (HI_W + 20)'(US_PER_S);
            r_x    <= (X_W'(r_hi) << LO_W) + X_W'(r_lo);
            r_h    <= r_x[X_W-1:SAMPLE_W];
            r_s    <= (H_W + 1)'(r_x[X_W-1:SAMPLE_W]) + (H_W + 1)'(r_x[SAMPLE_W-1:0]);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_status <= r_status;
            r_o_ts     <= r_ts;
            r_o_count  <= COUNT_OUT_W'(r_count);
        end
    end

    assign o_status       = r_o_status;
    assign o_timestamp_us = r_o_ts;
    assign o_entry_count  = r_o_count;

endmodule

// ===== design/srtt_ctrl.sv =====
// ----------------------------------------------------------------------------
// srtt_ctrl
// Controller: sequences one request at a time through dispatch, the insert
// scan or the read and scale steps, and hands the result to the output
// register when it is free.
// ----------------------------------------------------------------------------
module srtt_ctrl
    import srtt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_CMP,
        S_RD_MUL1,
        S_RD_MUL2,
        S_RD_SUM,
        S_RD_FOLD,
        S_RD_QUOT,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.status = ST_OK;
        n_out_valid = r_out_valid & ~i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.kind)
                    KIND_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.status_we = 1'b1;
                            o_cmd.status    = ST_FULL;
                            n_state         = S_FINISH;
                        end else begin
                            o_cmd.rd_ins = 1'b1;
                            n_state      = S_INS_CMP;
                        end
                    end
                    KIND_READ: begin
                        if (i_stat.rank_bad) begin
                            o_cmd.status_we = 1'b1;
                            o_cmd.status    = ST_RANGE;
                            n_state         = S_FINISH;
                        end else begin
                            o_cmd.rd_rank = 1'b1;
                            n_state       = S_RD_MUL1;
                        end
                    end
                    KIND_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_FINISH;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            // one entry moved per cycle until the slot is found
            S_INS_CMP: begin
                if (i_stat.shift_go) begin
                    o_cmd.ins_shift = 1'b1;
                end else begin
                    o_cmd.ins_place = 1'b1;
                    n_state         = S_FINISH;
                end
            end
            S_RD_MUL1: begin
                o_cmd.scale_en = 1'b1;
                n_state        = S_RD_MUL2;
            end
            S_RD_MUL2: begin
                o_cmd.scale_en = 1'b1;
                n_state        = S_RD_SUM;
            end
            S_RD_SUM: begin
                o_cmd.scale_en = 1'b1;
                n_state        = S_RD_FOLD;
            end
            S_RD_FOLD: begin
                o_cmd.scale_en = 1'b1;
                n_state        = S_RD_QUOT;
            end
            S_RD_QUOT: begin
                o_cmd.ts_load = 1'b1;
                n_state       = S_FINISH;
            end
            // wait for the output register to free up
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== design/sorted_random_timestamp_table.sv =====
// ----------------------------------------------------------------------------
// sorted_random_timestamp_table
// Keeps 32-bit samples in ascending order and returns entries by rank,
// scaled to microseconds of the benchmark window.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request: kind 0
//   inserts i_sample_value, kind 1 reads the entry at i_rank, kind 2 clears.
//   Every request gives one result on the output channel (o_out_valid /
//   i_out_ready): status, timestamp_us (reads only, else zero) and the
//   entry count after the request.
//   i_cfg_we writes the window length in seconds; write it while idle.
//   Requests are handled one at a time. An insert moves every held entry
//   larger than the sample (up to TABLE_DEPTH - 1 of them) up one place,
//   starting from the top; the insert scan moves one entry per cycle
//   through the single memory write port.
//   A finished result sits in the output register while the next request is
//   accepted and worked on; it only waits if that register is still full.
//   Reset empties the table and sets the window to 10 seconds; no clearing
//   pass is needed since only written entries are ever read.
// ----------------------------------------------------------------------------
module sorted_random_timestamp_table
    import srtt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [SECS_W-1:0]      i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [KIND_W-1:0]      i_kind,
    input  logic [SAMPLE_W-1:0]    i_sample_value,
    input  logic [RANK_W-1:0]      i_rank,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [STATUS_W-1:0]    o_status,
    output logic [TS_W-1:0]        o_timestamp_us,
    output logic [COUNT_OUT_W-1:0] o_entry_count
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // request sequencer
    srtt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // table, count and scaling
    srtt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_kind         (i_kind),
        .i_sample_value (i_sample_value),
        .i_rank         (i_rank),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_status       (o_status),
        .o_timestamp_us (o_timestamp_us),
        .o_entry_count  (o_entry_count)
    );

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted sample table: drives insert, read, clear
// and unused requests with random idling on both channels, tracks the sorted
// contents and the window length in a scoreboard, and checks every result in
// order against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb;
    import srtt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH     = DEF_TABLE_DEPTH;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 6000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int FILL_ITEMS      = 120;
    localparam int RANDOM_ITEMS    = 420;
    localparam int RANDOM_PHASES   = 6;
    localparam int REFILL_LIMIT    = 200;

    // kind code with no function in the block
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        t_status                status;
        logic [TS_W-1:0]        ts;
        logic [COUNT_OUT_W-1:0] count;
    } t_table_result;

    // scoreboard: sorted contents, window length and results still owed
    class timestamp_table_checker;
        logic [SAMPLE_W-1:0] held_samples [TABLE_DEPTH];
        int unsigned         held_count;
        logic [SECS_W-1:0]   window_secs;
        t_table_result       pending_results [$];
        int unsigned         mismatches;

        function new();
            held_count  = 0;
            window_secs = SECS_RESET;
            mismatches  = 0;
        endfunction

        function void set_window(logic [SECS_W-1:0] secs);
            window_secs = secs;
        endfunction

        // exact floor of sample * seconds * 1e6 / full scale, saturated
        function logic [TS_W-1:0] to_microseconds(logic [SAMPLE_W-1:0] sample);
            logic [79:0] scaled;
            scaled = ({48'd0, sample} * window_secs * US_PER_S) / FULL_SCALE;
            if (scaled > 80'hFFFF_FFFF) begin
                return '1;
            end
            return scaled[TS_W-1:0];
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, logic [SAMPLE_W-1:0] sample,
                                   logic [RANK_W-1:0] rank);
            t_table_result want;
            int            slot;
            want.status = ST_OK;
            want.ts     = '0;
            case (kind)
                KIND_INSERT: begin
                    if (held_count >= TABLE_DEPTH) begin
                        want.status = ST_FULL;
                    end else begin
                        // first slot holding a larger value; equal ones stay below
                        slot = 0;
                        while (slot < held_count && held_samples[slot] <= sample) begin
                            slot++;
                        end
                        for (int k = held_count; k > slot; k--) begin
                            held_samples[k] = held_samples[k-1];
                        end
                        held_samples[slot] = sample;
                        held_count++;
                    end
                end
                KIND_READ: begin
                    if (rank >= held_count) begin
                        want.status = ST_RANGE;
                    end else begin
                        want.ts = to_microseconds(held_samples[rank]);
                    end
                end
                KIND_CLEAR: begin
                    held_count = 0;
                end
                default: ;
            endcase
            want.count = held_count[COUNT_OUT_W-1:0];
            pending_results.push_back(want);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [TS_W-1:0] ts,
                                   logic [COUNT_OUT_W-1:0] count);
            t_table_result want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: status %0d ts %0d count %0d",
                             status, ts, count);
                end
                return;
            end
            want = pending_results.pop_front();
            if (status !== want.status || ts !== want.ts || count !== want.count) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("mismatch: expected status %0d ts %0d count %0d, ",
                           want.status, want.ts, want.count);
                    $display("got status %0d ts %0d count %0d", status, ts, count);
                end
            end
        endfunction
    endclass

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_cfg_we       = 1'b0;
    logic [SECS_W-1:0]      i_cfg_wdata    = '0;
    logic                   i_in_valid     = 1'b0;
    logic                   o_in_ready;
    logic [KIND_W-1:0]      i_kind         = KIND_CLEAR;
    logic [SAMPLE_W-1:0]    i_sample_value = '0;
    logic [RANK_W-1:0]      i_rank         = '0;
    logic                   o_out_valid;
    logic                   i_out_ready    = 1'b0;
    logic [STATUS_W-1:0]    o_status;
    logic [TS_W-1:0]        o_timestamp_us;
    logic [COUNT_OUT_W-1:0] o_entry_count;

    timestamp_table_checker table_check;
    bit          hold_off_request = 1'b0;
    int unsigned send_burst_left  = 0;
    int unsigned idle_cycles      = 0;

    sorted_random_timestamp_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_sample_value (i_sample_value),
        .i_rank         (i_rank),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_timestamp_us (o_timestamp_us),
        .o_entry_count  (o_entry_count)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // offer one request after a random gap and wait until it is taken
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [SAMPLE_W-1:0] sample,
                                input logic [RANK_W-1:0] rank);
        int gap;
        if (send_burst_left > 0) begin
            gap = 0;
            send_burst_left--;
        end else begin
            gap = $urandom_range(0, 5);
            if ($urandom_range(0, 40) == 0) begin
                send_burst_left = $urandom_range(10, 40);
            end
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_sample_value <= sample;
        i_rank         <= rank;
        do begin
            @(posedge i_clk);
        end while (o_in_ready !== 1'b1);
        table_check.note_request(kind, sample, rank);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (table_check.pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // window length is only changed with the block idle
    task automatic write_window(input logic [SECS_W-1:0] secs);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= secs;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        table_check.set_window(secs);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
            return $urandom();
        end else if (sel < 75) begin
            return $urandom_range(0, 15);
        end else if (sel < 80) begin
            return '1;
        end else if (sel < 85) begin
            return 32'h8000_0000;
        end else if (table_check.held_count > 0) begin
            // repeat a held value to exercise equal ordering
            return table_check.held_samples[$urandom_range(0, table_check.held_count - 1)];
        end
        return '0;
    endfunction

    // random mix: bursts of inserts and reads on a small table, clears, noise
    task automatic run_random_mix(input int unsigned n_items);
        int unsigned sent;
        int unsigned sel;
        int unsigned n;
        logic [RANK_W-1:0] rank;
        sent = 0;
        while (sent < n_items) begin
            sel = $urandom_range(0, 99);
            if (sel < 8 || table_check.held_count > REFILL_LIMIT) begin
                send_request(KIND_CLEAR, $urandom(), RANK_W'($urandom()));
                sent++;
            end else if (sel < 55) begin
                n = $urandom_range(1, 12);
                for (int k = 0; k < n; k++) begin
                    send_request(KIND_INSERT, pick_sample(), RANK_W'($urandom()));
                    sent++;
                end
            end else if (sel < 92) begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++) begin
                    if (table_check.held_count > 0 && $urandom_range(0, 99) < 85) begin
                        rank = RANK_W'($urandom_range(0, table_check.held_count - 1));
                    end else begin
                        rank = RANK_W'($urandom());
                    end
                    send_request(KIND_READ, $urandom(), rank);
                    sent++;
                end
            end else if (sel < 96) begin
                send_request(KIND_UNUSED, $urandom(), RANK_W'($urandom()));
            end else begin
                send_request(KIND_W'($urandom_range(0, 2)), $urandom(), RANK_W'($urandom()));
                sent++;
            end
        end
    endtask

    // result side: random stalls, burst stretches and one long hold-off
    initial begin : result_drain
        int unsigned stall;
        int unsigned burst_left;
        int unsigned hold_left;
        stall      = 0;
        burst_left = 0;
        hold_left  = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready) begin
                table_check.check_result(o_status, o_timestamp_us, o_entry_count);
                if (burst_left > 0) begin
                    stall = 0;
                    burst_left--;
                end else begin
                    stall = $urandom_range(0, 5);
                    if ($urandom_range(0, 40) == 0) begin
                        burst_left = $urandom_range(10, 40);
                    end
                end
            end
            if (hold_off_request) begin
                hold_left        = HOLD_OFF_CYCLES;
                hold_off_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // main sequence
    initial begin : stimulus
        logic [SAMPLE_W-1:0] sample;
        logic [SECS_W-1:0]   window_plan [RANDOM_PHASES];
        table_check = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty reads, extremes, equal samples, unused kind, clear
        send_request(KIND_READ, '0, '0);
        send_request(KIND_INSERT, '1, '0);
        send_request(KIND_INSERT, '0, '1);
        send_request(KIND_INSERT, 32'h8000_0000, '0);
        send_request(KIND_INSERT, 32'h8000_0000, '0);
        send_request(KIND_INSERT, 32'd1, '0);
        for (int r = 0; r < 6; r++) begin
            send_request(KIND_READ, '0, RANK_W'(r));
        end
        send_request(KIND_READ, '1, '1);
        send_request(KIND_UNUSED, $urandom(), RANK_W'($urandom()));
        send_request(KIND_CLEAR, '0, '0);
        send_request(KIND_READ, '0, '0);
        send_request(KIND_INSERT, 32'h7FFF_FFFF, '0);
        send_request(KIND_READ, '0, '0);

        // larger fill, mostly ascending with equal runs and a few late low ones
        write_window(13'd4294);
        send_request(KIND_CLEAR, '0, '0);
        for (int i = 0; i < FILL_ITEMS; i++) begin
            if (i % 23 == 11) begin
                sample = $urandom();
            end else if (i % 5 != 1) begin
                sample = SAMPLE_W'(i << 25) | SAMPLE_W'($urandom_range(0, (1 << 25) - 1));
            end
            send_request(KIND_INSERT, sample, RANK_W'($urandom()));
        end
        send_request(KIND_INSERT, '0, '0);
        send_request(KIND_INSERT, '1, '0);
        send_request(KIND_INSERT, $urandom(), RANK_W'($urandom()));
        send_request(KIND_READ, '0, 10'd1023);
        send_request(KIND_READ, '0, 10'd0);
        send_request(KIND_READ, '0, RANK_W'(FILL_ITEMS / 2));
        send_request(KIND_READ, '0, RANK_W'(FILL_ITEMS + 2));
        send_request(KIND_READ, '0, RANK_W'($urandom()));

        // widest windows saturate on the top entries
        write_window('1);
        send_request(KIND_READ, '0, RANK_W'(FILL_ITEMS + 2));
        send_request(KIND_READ, '0, RANK_W'(FILL_ITEMS - 10));
        send_request(KIND_READ, '0, 10'd0);
        write_window(13'd4295);
        send_request(KIND_READ, '0, RANK_W'(FILL_ITEMS + 2));
        send_request(KIND_READ, '0, RANK_W'($urandom()));
        send_request(KIND_CLEAR, '0, '0);

        // random phases, each under its own window length
        window_plan[0] = 13'd1;
        window_plan[1] = 13'd4294;
        window_plan[2] = '1;
        window_plan[3] = '0;
        window_plan[4] = SECS_W'($urandom_range(1, 4294));
        window_plan[5] = SECS_W'($urandom());
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_window(window_plan[p]);
            if (p == 1) begin
                // receiver stops for a long stretch while requests keep coming
                hold_off_request = 1'b1;
            end
            run_random_mix(RANDOM_ITEMS / RANDOM_PHASES);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (table_check.mismatches == 0 && table_check.pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
